FILE: rtl/irc_tok_pkg.sv
// Shared types and constants for the IRC line tokenizer.
package irc_tok_pkg;

    localparam int TOKEN_INDEX_MAX = 63;
    localparam int IDX_W           = 6;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [2:0] {
        M_LEAD       = 3'd0,
        M_CMD        = 3'd1,
        M_SEP        = 3'd2,
        M_MID        = 3'd3,
        M_TRAIL      = 3'd4,
        M_DONE_OK    = 3'd5,
        M_DONE_EMPTY = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        K_SPACE   = 3'd0,
        K_COMMAND = 3'd1,
        K_MIDDLE  = 3'd2,
        K_COLON   = 3'd3,
        K_TRAIL   = 3'd4,
        K_TERM    = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        V_VALID = 2'd0,
        V_EMPTY = 2'd1,
        V_NOEOL = 2'd2
    } verdict_t;

    typedef struct packed {
        mode_t            mode;
        logic [IDX_W-1:0] count;
        logic [7:0]       data;
        logic             crlf;
    } cls_in_t;

    typedef struct packed {
        mode_t            mode;
        logic [IDX_W-1:0] count;
        kind_t            kind;
        logic             start;
    } cls_out_t;

    typedef struct packed {
        logic [7:0]       data;
        kind_t            kind;
        logic             start;
        logic [IDX_W-1:0] index;
        logic             eol;
        verdict_t         verdict;
    } result_t;

endpackage

FILE: rtl/irc_tok_classify.sv
// Classifies one byte against the current parse mode and updates mode and token count.
module irc_tok_classify
(
    input  irc_tok_pkg::cls_in_t  cin,
    output irc_tok_pkg::cls_out_t cout
);
    import irc_tok_pkg::*;

    logic             is_sp;
    logic             is_colon;
    logic [IDX_W-1:0] bumped;

    assign is_sp    = (cin.data == CH_SP);
    assign is_colon = (cin.data == CH_COLON);
    // saturate at the top index
    assign bumped   = (cin.count < IDX_W'(TOKEN_INDEX_MAX)) ? cin.count + 1'b1
                                                            : IDX_W'(TOKEN_INDEX_MAX);

    always_comb
    begin
        cout.mode  = cin.mode;
        cout.count = cin.count;
        cout.kind  = K_TERM;
        cout.start = 1'b0;
        unique case (cin.mode)
            M_LEAD:
            begin
                priority if (is_sp)
                    cout.kind = K_SPACE;
                else if (cin.crlf)
                    cout.mode = M_DONE_EMPTY;
                else
                begin
                    cout.kind  = K_COMMAND;
                    cout.start = 1'b1;
                    cout.count = '0;
                    cout.mode  = M_CMD;
                end
            end
            M_CMD, M_MID:
            begin
                priority if (is_sp)
                begin
                    cout.kind = K_SPACE;
                    cout.mode = M_SEP;
                end
                else if (cin.crlf)
                    cout.mode = M_DONE_OK;
                else
                    cout.kind = (cin.mode == M_CMD) ? K_COMMAND : K_MIDDLE;
            end
            M_SEP:
            begin
                priority if (is_sp)
                    cout.kind = K_SPACE;
                else if (cin.crlf)
                    cout.mode = M_DONE_OK;
                else if (is_colon)
                begin
                    cout.count = bumped;
                    cout.kind  = K_COLON;
                    cout.start = 1'b1;
                    cout.mode  = M_TRAIL;
                end
                else
                begin
                    cout.count = bumped;
                    cout.kind  = K_MIDDLE;
                    cout.start = 1'b1;
                    cout.mode  = M_MID;
                end
            end
            M_TRAIL:
            begin
                if (cin.crlf)
                    cout.mode = M_DONE_OK;
                else
                    cout.kind = K_TRAIL;
            end
            default:
                cout.kind = K_TERM;
        endcase
    end

endmodule

FILE: rtl/irc_line_tokenizer_top.sv
// Top level of the IRC line tokenizer: byte stream in, tagged byte stream out.
//
// Usage:
//   s_axis carries one character per item in tdata; tlast marks the final
//   byte of a line. m_axis returns one tagged result per input byte, in
//   order. Each byte is held until the next one arrives, because a CR is the
//   terminator only when an LF follows it; the byte flagged tlast is tagged
//   at once, so the last item of a line yields two results if a byte is held.
//   A byte's result is written into the result queue when the following
//   byte is accepted (when the tlast byte itself is accepted, for that byte).
//   Throughput: one input item per cycle; a line of N bytes yields N
//   results. Results sit in a four-entry result queue; input is taken while
//   at least two entries are free, so tready drops only when the receiver
//   stalls and the queue fills.
//   m_axis tlast marks the last result of a line and tdata carries the
//   verdict there (valid, empty command, no CRLF).
//   Reset clears the parse state, drops the held byte and empties the queue.
module irc_line_tokenizer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // line_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [13:8] token_index, [15:14] verdict
    output logic [3:0]  m_axis_tuser,   // [2:0] byte_kind, [3] token_start
    output logic        m_axis_tlast    // end_of_line
);
    import irc_tok_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // parse state
    mode_t            mode_reg, mode_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic [7:0]       held_reg, held_next;
    logic             held_valid_reg, held_valid_next;

    // result queue
    result_t             q_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     fill_reg, fill_next;

    logic    accept, pop;
    cls_in_t  c0_in, c1_in;
    cls_out_t c0_out, c1_out;
    result_t  res0, res1;
    logic [1:0] push_n;

    assign s_axis_tready = (fill_reg <= (QPTR_W+1)'(QDEPTH - 2));
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (fill_reg != '0);
    assign pop           = m_axis_tvalid && m_axis_tready;

    // first classifier: the held byte, with the new byte as lookahead
    assign c0_in.mode  = mode_reg;
    assign c0_in.count = count_reg;
    assign c0_in.data  = held_reg;
    assign c0_in.crlf  = (held_reg == CH_CR) && (s_axis_tdata == CH_LF);

    irc_tok_classify u_cls_held
    (
        .cin  (c0_in),
        .cout (c0_out)
    );

    // second classifier: the new byte when it ends the line, no lookahead
    assign c1_in.mode  = held_valid_reg ? c0_out.mode  : mode_reg;
    assign c1_in.count = held_valid_reg ? c0_out.count : count_reg;
    assign c1_in.data  = s_axis_tdata;
    assign c1_in.crlf  = 1'b0;

    irc_tok_classify u_cls_last
    (
        .cin  (c1_in),
        .cout (c1_out)
    );

    always_comb
    begin
        res0.data    = held_reg;
        res0.kind    = c0_out.kind;
        res0.start   = c0_out.start;
        res0.index   = c0_out.count;
        res0.eol     = 1'b0;
        res0.verdict = V_VALID;

        res1.data    = s_axis_tdata;
        res1.kind    = c1_out.kind;
        res1.start   = c1_out.start;
        res1.index   = c1_out.count;
        res1.eol     = 1'b1;
        priority if (c1_out.mode == M_DONE_OK)
            res1.verdict = V_VALID;
        else if (c1_out.mode == M_DONE_EMPTY || c1_out.mode == M_LEAD)
            res1.verdict = V_EMPTY;
        else
            res1.verdict = V_NOEOL;
    end

    // next parse state
    always_comb
    begin
        mode_next       = mode_reg;
        count_next      = count_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        push_n          = 2'd0;
        if (accept)
        begin
            push_n = {1'b0, held_valid_reg} + {1'b0, s_axis_tlast};
            if (s_axis_tlast)
            begin
                // line done: return to reset state
                mode_next       = M_LEAD;
                count_next      = '0;
                held_next       = '0;
                held_valid_next = 1'b0;
            end
            else
            begin
                if (held_valid_reg)
                begin
                    mode_next  = c0_out.mode;
                    count_next = c0_out.count;
                end
                held_next       = s_axis_tdata;
                held_valid_next = 1'b1;
            end
        end
        fill_next = fill_reg + (QPTR_W+1)'(push_n) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= M_LEAD;
            count_reg      <= '0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fill_reg       <= '0;
        end
        else
        begin
            mode_reg       <= mode_next;
            count_reg      <= count_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            wr_ptr_reg     <= wr_ptr_reg + QPTR_W'(push_n);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fill_reg       <= fill_next;
        end
    end

    // queue payload: held byte result first, then the line-end result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            priority if (held_valid_reg)
            begin
                q_reg[wr_ptr_reg] <= res0;
                if (s_axis_tlast)
                    q_reg[wr_ptr_reg + 1'b1] <= res1;
            end
            else if (s_axis_tlast)
                q_reg[wr_ptr_reg] <= res1;
        end
    end

    assign m_axis_tdata = {q_reg[rd_ptr_reg].verdict, q_reg[rd_ptr_reg].index,
                           q_reg[rd_ptr_reg].data};
    assign m_axis_tuser = {q_reg[rd_ptr_reg].start, q_reg[rd_ptr_reg].kind};
    assign m_axis_tlast = q_reg[rd_ptr_reg].eol;

endmodule
